@@ hdl/lvm_pkg.sv @@
`default_nettype none
package lvm_pkg;

	// Rotation entries are Q2.30, so one unit sits at this bit.
	localparam int FRAC_BITS = 30;

	typedef logic signed [31:0] unit_t;

	typedef enum logic [1:0] {
		ROW_SIDE = 2'd0,
		ROW_UP   = 2'd1,
		ROW_FWD  = 2'd2
	} row_t;

endpackage
`default_nettype wire

@@ hdl/lvm_norm.sv @@
`default_nettype none
// Pipelined normalizer: the magnitudes are scaled so that the largest has its top bit at
// bit 30. An integer square root follows, one result bit per stage. Then each component
// is divided by the root, one quotient bit per stage.
module lvm_norm #(
	parameter int VW  = 33,
	parameter int SBW = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_vld,
	input  wire logic signed [VW-1:0]  in_v [3],
	input  wire logic [SBW-1:0]        in_sb,
	output logic                       out_vld,
	output logic                       out_ok,
	output lvm_pkg::unit_t             out_u [3],
	output logic [SBW-1:0]             out_sb
);

	localparam int PW = $clog2(VW);
	localparam int RS = 32;
	localparam int QS = lvm_pkg::FRAC_BITS + 1;
	localparam int NB = 2 * lvm_pkg::FRAC_BITS + 2;
	localparam logic [PW-1:0] TOP = PW'(lvm_pkg::FRAC_BITS);

	logic [VW-1:0] mag_c [3];
	logic [VW-1:0] max01_c, max_c;
	logic [PW-1:0] pos_c;
	logic [30:0]   an_c [3];

	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic [VW-1:0] mag_s1 [3];
	logic [VW-1:0] mag_s2 [3];
	logic [2:0]    neg_s1, neg_s2, neg_s3, neg_s4;
	logic [VW-1:0] max_s1;
	logic [PW-1:0] pos_s2;
	logic          nz_s2, nz_s3, nz_s4;
	logic [30:0]   an_s3 [3];
	logic [30:0]   an_s4 [3];
	logic [61:0]   sq_s4 [3];
	logic [SBW-1:0] sb_s1, sb_s2, sb_s3, sb_s4;

	// Square root section, index 0 holds the sum of squares.
	logic [RS:0]    rvld_s;
	logic [63:0]    rv_s [0:RS];
	logic [63:0]    rr_s [0:RS];
	logic [30:0]    ra_s [0:RS][3];
	logic [2:0]     rneg_s [0:RS];
	logic [RS:0]    rnz_s;
	logic [SBW-1:0] rsb_s [0:RS];
	logic [63:0]    rtrial [RS];

	// Division section, index 0 holds the rounded numerators.
	logic [QS:0]    dvld_s;
	logic [NB-1:0]  drem_s [0:QS][3];
	logic [30:0]    dq_s [0:QS][3];
	logic [31:0]    dd_s [0:QS];
	logic [2:0]     dneg_s [0:QS];
	logic [QS:0]    dnz_s;
	logic [SBW-1:0] dsb_s [0:QS];
	logic [NB-1:0]  dsh [QS];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = in_v[i][VW-1] ? VW'(-in_v[i]) : VW'(in_v[i]);
		end
		max01_c = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
		max_c   = (mag_c[2] > max01_c) ? mag_c[2] : max01_c;
	end

	always_comb begin
		pos_c = '0;
		for (int b = 0; b < VW; b++) begin
			if (max_s1[b]) begin
				pos_c = PW'(b);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= TOP) begin
				an_c[i] = 31'(mag_s2[i] >> (pos_s2 - TOP));
			end else begin
				an_c[i] = 31'(mag_s2[i] << (TOP - pos_s2));
			end
		end
	end

	always_comb begin
		for (int k = 0; k < RS; k++) begin
			rtrial[k] = rr_s[k] + (64'd1 << (2 * (RS - 1 - k)));
		end
		for (int j = 0; j < QS; j++) begin
			dsh[j] = NB'(dd_s[j]) << (QS - 1 - j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			rvld_s  <= '0;
			dvld_s  <= '0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			rvld_s  <= {rvld_s[RS-1:0], vld_s4};
			dvld_s  <= {dvld_s[QS-1:0], rvld_s[RS]};
			out_vld <= dvld_s[QS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_c[i];
				neg_s1[i] <= in_v[i][VW-1];
			end
			max_s1 <= max_c;
			sb_s1  <= in_sb;

			pos_s2 <= pos_c;
			nz_s2  <= |max_s1;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			sb_s2  <= sb_s1;

			an_s3  <= an_c;
			nz_s3  <= nz_s2;
			neg_s3 <= neg_s2;
			sb_s3  <= sb_s2;

			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= 62'(an_s3[i]) * 62'(an_s3[i]);
			end
			an_s4  <= an_s3;
			nz_s4  <= nz_s3;
			neg_s4 <= neg_s3;
			sb_s4  <= sb_s3;

			rv_s[0]   <= 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
			rr_s[0]   <= '0;
			ra_s[0]   <= an_s4;
			rneg_s[0] <= neg_s4;
			rnz_s[0]  <= nz_s4;
			rsb_s[0]  <= sb_s4;
			for (int k = 0; k < RS; k++) begin
				if (rv_s[k] >= rtrial[k]) begin
					rv_s[k+1] <= rv_s[k] - rtrial[k];
					rr_s[k+1] <= (rr_s[k] >> 1) + (64'd1 << (2 * (RS - 1 - k)));
				end else begin
					rv_s[k+1] <= rv_s[k];
					rr_s[k+1] <= rr_s[k] >> 1;
				end
				ra_s[k+1]   <= ra_s[k];
				rneg_s[k+1] <= rneg_s[k];
				rnz_s[k+1]  <= rnz_s[k];
				rsb_s[k+1]  <= rsb_s[k];
			end

			// Numerator is the scaled magnitude with half the divisor added for rounding.
			for (int i = 0; i < 3; i++) begin
				drem_s[0][i] <= (NB'(ra_s[RS][i]) << lvm_pkg::FRAC_BITS) + NB'(rr_s[RS][31:1]);
				dq_s[0][i]   <= '0;
			end
			dd_s[0]   <= rr_s[RS][31:0];
			dneg_s[0] <= rneg_s[RS];
			dnz_s[0]  <= rnz_s[RS];
			dsb_s[0]  <= rsb_s[RS];
			for (int j = 0; j < QS; j++) begin
				for (int i = 0; i < 3; i++) begin
					if (drem_s[j][i] >= dsh[j]) begin
						drem_s[j+1][i] <= drem_s[j][i] - dsh[j];
						dq_s[j+1][i]   <= dq_s[j][i] | (31'd1 << (QS - 1 - j));
					end else begin
						drem_s[j+1][i] <= drem_s[j][i];
						dq_s[j+1][i]   <= dq_s[j][i];
					end
				end
				dd_s[j+1]   <= dd_s[j];
				dneg_s[j+1] <= dneg_s[j];
				dnz_s[j+1]  <= dnz_s[j];
				dsb_s[j+1]  <= dsb_s[j];
			end

			for (int i = 0; i < 3; i++) begin
				out_u[i] <= dneg_s[QS][i] ? -lvm_pkg::unit_t'(dq_s[QS][i])
					: lvm_pkg::unit_t'(dq_s[QS][i]);
			end
			out_ok <= dnz_s[QS];
			out_sb <= dsb_s[QS];
		end
	end

endmodule
`default_nettype wire

@@ hdl/lookat_view_matrix.sv @@
// Each camera leaves as three output transactions through the one-matrix output buffer;
// the pipeline itself can take a transaction in every cycle until that buffer backs it up.
// Reset: arst_n clears every valid bit and the output buffer at once; data registers are
// not reset.
`default_nettype none
module lookat_view_matrix (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] eye_x,
	input  wire logic signed [31:0] eye_y,
	input  wire logic signed [31:0] eye_z,
	input  wire logic signed [31:0] target_x,
	input  wire logic signed [31:0] target_y,
	input  wire logic signed [31:0] target_z,
	input  wire logic signed [31:0] up_x,
	input  wire logic signed [31:0] up_y,
	input  wire logic signed [31:0] up_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              row_index,
	output logic signed [31:0]      axis_x,
	output logic signed [31:0]      axis_y,
	output logic signed [31:0]      axis_z,
	output logic signed [31:0]      offset,
	output logic                    degenerate,
	output logic                    last_row
);

	// Side data that rides along with each normalizer.
	typedef struct packed {
		logic [2:0][31:0] eye;
		logic [2:0][31:0] up;
	} cam_t;

	typedef struct packed {
		logic [2:0][31:0] eye;
		logic [2:0][31:0] f;
		logic             ok;
	} fwd_t;

	// Round a Q.60 or Q.46 product sum by 30 bits, halves away from zero, in one add.
	function automatic logic signed [33:0] rnd30(input logic signed [63:0] x);
		logic signed [63:0] y;
		y = x + (x[63] ? 64'sd536870911 : 64'sd536870912);
		return y[63:30];
	endfunction

	function automatic lvm_pkg::unit_t sat32(input logic signed [33:0] x);
		if (x > 34'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (x < -34'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic lvm_pkg::unit_t clamp_unit(input logic signed [33:0] x);
		if (x > 34'sd1073741824) begin
			return 32'sd1073741824;
		end else if (x < -34'sd1073741824) begin
			return -32'sd1073741824;
		end
		return x[31:0];
	endfunction

	// Global advance: the whole pipeline moves unless its last stage is full and the
	// output buffer cannot take it.
	logic en;
	logic buf_free;
	logic out_fire;

	// Stage 1: forward difference.
	logic               vld_s1;
	logic signed [32:0] d_s1 [3];
	cam_t               cam_s1;

	// Forward normalizer.
	logic           n1_vld, n1_ok;
	lvm_pkg::unit_t n1_u [3];
	cam_t           n1_sb;

	// Stages 2 and 3: cross(f, up).
	logic               vld_s2, vld_s3;
	logic signed [63:0] pc_s2 [6];
	fwd_t               fw_s2, fw_s3;
	logic signed [63:0] c_s3 [3];

	// Side normalizer.
	logic           n2_vld, n2_ok;
	lvm_pkg::unit_t n2_u [3];
	fwd_t           n2_sb;

	// Stages 4 to 9: true up and the three offsets.
	logic               vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic               ok_s4, ok_s5, ok_s6, ok_s7, ok_s8, ok_s9;
	lvm_pkg::unit_t     s_s4 [3], s_s5 [3], s_s6 [3], s_s7 [3], s_s8 [3], s_s9 [3];
	lvm_pkg::unit_t     f_s4 [3], f_s5 [3], f_s6 [3], f_s7 [3], f_s8 [3], f_s9 [3];
	lvm_pkg::unit_t     eye_s4 [3], eye_s5 [3], eye_s6 [3];
	logic signed [63:0] p_s4 [6];
	logic signed [63:0] se_s4 [3];
	logic signed [63:0] fe_s4 [3];
	logic signed [63:0] ud_s5 [3];
	logic signed [63:0] nd0_s5, d2_s5;
	lvm_pkg::unit_t     u_s6 [3], u_s7 [3], u_s8 [3], u_s9 [3];
	lvm_pkg::unit_t     off0_s6, off0_s7, off0_s8, off0_s9;
	lvm_pkg::unit_t     off2_s6, off2_s7, off2_s8, off2_s9;
	logic signed [63:0] ue_s7 [3];
	logic signed [63:0] nd1_s8;
	lvm_pkg::unit_t     off1_s9;

	// Output buffer: one whole matrix, sent one row per transaction.
	logic              bv_q;
	lvm_pkg::row_t     row_q;
	lvm_pkg::unit_t    ax_q [3][3];
	lvm_pkg::unit_t    off_q [3];
	logic              deg_q;

	assign out_fire = bv_q && !out_stall;
	assign buf_free = !bv_q || (out_fire && (row_q == lvm_pkg::ROW_FWD));
	assign en       = !vld_s9 || buf_free;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= n1_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= n2_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= $signed({target_x[31], target_x}) - $signed({eye_x[31], eye_x});
			d_s1[1] <= $signed({target_y[31], target_y}) - $signed({eye_y[31], eye_y});
			d_s1[2] <= $signed({target_z[31], target_z}) - $signed({eye_z[31], eye_z});
			cam_s1.eye <= {eye_z, eye_y, eye_x};
			cam_s1.up  <= {up_z, up_y, up_x};

			// cross(f, up) as six exact products, then their differences.
			pc_s2[0] <= n1_u[1] * $signed(n1_sb.up[2]);
			pc_s2[1] <= n1_u[2] * $signed(n1_sb.up[1]);
			pc_s2[2] <= n1_u[2] * $signed(n1_sb.up[0]);
			pc_s2[3] <= n1_u[0] * $signed(n1_sb.up[2]);
			pc_s2[4] <= n1_u[0] * $signed(n1_sb.up[1]);
			pc_s2[5] <= n1_u[1] * $signed(n1_sb.up[0]);
			fw_s2.eye <= n1_sb.eye;
			fw_s2.f   <= {n1_u[2], n1_u[1], n1_u[0]};
			fw_s2.ok  <= n1_ok;

			c_s3[0] <= pc_s2[0] - pc_s2[1];
			c_s3[1] <= pc_s2[2] - pc_s2[3];
			c_s3[2] <= pc_s2[4] - pc_s2[5];
			fw_s3   <= fw_s2;

			// Products for cross(s, f) and for the side and forward offsets.
			p_s4[0] <= n2_u[1] * $signed(n2_sb.f[2]);
			p_s4[1] <= n2_u[2] * $signed(n2_sb.f[1]);
			p_s4[2] <= n2_u[2] * $signed(n2_sb.f[0]);
			p_s4[3] <= n2_u[0] * $signed(n2_sb.f[2]);
			p_s4[4] <= n2_u[0] * $signed(n2_sb.f[1]);
			p_s4[5] <= n2_u[1] * $signed(n2_sb.f[0]);
			for (int i = 0; i < 3; i++) begin
				se_s4[i]  <= n2_u[i] * $signed(n2_sb.eye[i]);
				fe_s4[i]  <= $signed(n2_sb.f[i]) * $signed(n2_sb.eye[i]);
				s_s4[i]   <= n2_u[i];
				f_s4[i]   <= $signed(n2_sb.f[i]);
				eye_s4[i] <= $signed(n2_sb.eye[i]);
			end
			ok_s4 <= n2_sb.ok && n2_ok;

			ud_s5[0] <= p_s4[0] - p_s4[1];
			ud_s5[1] <= p_s4[2] - p_s4[3];
			ud_s5[2] <= p_s4[4] - p_s4[5];
			nd0_s5   <= -(se_s4[0] + se_s4[1] + se_s4[2]);
			d2_s5    <= fe_s4[0] + fe_s4[1] + fe_s4[2];
			s_s5     <= s_s4;
			f_s5     <= f_s4;
			eye_s5   <= eye_s4;
			ok_s5    <= ok_s4;

			for (int i = 0; i < 3; i++) begin
				u_s6[i] <= clamp_unit(rnd30(ud_s5[i]));
			end
			off0_s6 <= sat32(rnd30(nd0_s5));
			off2_s6 <= sat32(rnd30(d2_s5));
			s_s6    <= s_s5;
			f_s6    <= f_s5;
			eye_s6  <= eye_s5;
			ok_s6   <= ok_s5;

			// The up row offset waits for the rounded up vector.
			for (int i = 0; i < 3; i++) begin
				ue_s7[i] <= u_s6[i] * eye_s6[i];
			end
			u_s7    <= u_s6;
			s_s7    <= s_s6;
			f_s7    <= f_s6;
			off0_s7 <= off0_s6;
			off2_s7 <= off2_s6;
			ok_s7   <= ok_s6;

			nd1_s8  <= -(ue_s7[0] + ue_s7[1] + ue_s7[2]);
			u_s8    <= u_s7;
			s_s8    <= s_s7;
			f_s8    <= f_s7;
			off0_s8 <= off0_s7;
			off2_s8 <= off2_s7;
			ok_s8   <= ok_s7;

			off1_s9 <= sat32(rnd30(nd1_s8));
			u_s9    <= u_s8;
			s_s9    <= s_s8;
			f_s9    <= f_s8;
			off0_s9 <= off0_s8;
			off2_s9 <= off2_s8;
			ok_s9   <= ok_s8;
		end
	end

	lvm_norm #(
		.VW  (33),
		.SBW ($bits(cam_t))
	) u_norm_fwd (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s1),
		.in_v    (d_s1),
		.in_sb   (cam_s1),
		.out_vld (n1_vld),
		.out_ok  (n1_ok),
		.out_u   (n1_u),
		.out_sb  (n1_sb)
	);

	lvm_norm #(
		.VW  (64),
		.SBW ($bits(fwd_t))
	) u_norm_side (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.in_v    (c_s3),
		.in_sb   (fw_s3),
		.out_vld (n2_vld),
		.out_ok  (n2_ok),
		.out_u   (n2_u),
		.out_sb  (n2_sb)
	);

	// Output buffer control. A new matrix is loaded in the same cycle that the last row of
	// the previous one leaves, so rows stream without gaps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q  <= 1'b0;
			row_q <= lvm_pkg::ROW_SIDE;
		end else if (vld_s9 && buf_free) begin
			bv_q  <= 1'b1;
			row_q <= lvm_pkg::ROW_SIDE;
		end else if (out_fire) begin
			unique case (row_q)
				lvm_pkg::ROW_SIDE: row_q <= lvm_pkg::ROW_UP;
				lvm_pkg::ROW_UP:   row_q <= lvm_pkg::ROW_FWD;
				default: begin
					row_q <= lvm_pkg::ROW_SIDE;
					bv_q  <= 1'b0;
				end
			endcase
		end
	end

	// A degenerate camera leaves all rotation entries and offsets at zero.
	always_ff @(posedge clk) begin
		if (vld_s9 && buf_free) begin
			for (int i = 0; i < 3; i++) begin
				ax_q[0][i] <= ok_s9 ? s_s9[i] : '0;
				ax_q[1][i] <= ok_s9 ? u_s9[i] : '0;
				ax_q[2][i] <= ok_s9 ? -f_s9[i] : '0;
			end
			off_q[0] <= ok_s9 ? off0_s9 : '0;
			off_q[1] <= ok_s9 ? off1_s9 : '0;
			off_q[2] <= ok_s9 ? off2_s9 : '0;
			deg_q    <= !ok_s9;
		end
	end

	assign out_valid  = bv_q;
	assign row_index  = row_q;
	assign degenerate = deg_q;
	assign last_row   = (row_q == lvm_pkg::ROW_FWD);

	always_comb begin
		unique case (row_q)
			lvm_pkg::ROW_SIDE: begin
				axis_x = ax_q[0][0];
				axis_y = ax_q[0][1];
				axis_z = ax_q[0][2];
				offset = off_q[0];
			end
			lvm_pkg::ROW_UP: begin
				axis_x = ax_q[1][0];
				axis_y = ax_q[1][1];
				axis_z = ax_q[1][2];
				offset = off_q[1];
			end
			lvm_pkg::ROW_FWD: begin
				axis_x = ax_q[2][0];
				axis_y = ax_q[2][1];
				axis_z = ax_q[2][2];
				offset = off_q[2];
			end
			default: begin
				axis_x = '0;
				axis_y = '0;
				axis_z = '0;
				offset = '0;
			end
		endcase
	end

`ifndef SYNTHESIS
	// The input side only backs up when a matrix is waiting at the output.
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while no result is offered");

	// Rows of one matrix leave in order side, up, forward.
	a_row_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_row |=>
			out_valid && (row_index == 2'($past(row_index) + 2'd1)))
		else $error("row sequence broken");

	// A degenerate matrix carries only zero entries.
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |->
			axis_x == 32'sd0 && axis_y == 32'sd0 && axis_z == 32'sd0 && offset == 32'sd0)
		else $error("degenerate row carries nonzero data");

	// Rotation entries never exceed one unit in magnitude.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			axis_x <= 32'sd1073741824 && axis_x >= -32'sd1073741824 &&
			axis_y <= 32'sd1073741824 && axis_y >= -32'sd1073741824 &&
			axis_z <= 32'sd1073741824 && axis_z >= -32'sd1073741824)
		else $error("rotation entry out of range");
`endif

endmodule
`default_nettype wire

@@ sim/tb_lookat_view_matrix.sv @@
`default_nettype none
// Self-checking bench for the look-at view matrix block. A behavioral model
// of the fixed-point camera math predicts three rows per camera transaction,
// and a small scoreboard compares each output row with the oldest predicted row.
module tb_lookat_view_matrix;

	// One predicted or observed output row.
	typedef struct packed {
		lvm_pkg::row_t row;
		logic [31:0]   ax;
		logic [31:0]   ay;
		logic [31:0]   az;
		logic [31:0]   ofs;
		logic          degen;
		logic          last;
	} view_row_t;

	// Holds the predicted rows in arrival order and checks each observed row
	// against the oldest one.
	class view_row_board;
		view_row_t pending[$];
		int        errors;
		int        cameras;
		int        rows_seen;
		int        degen_seen;

		function void note_camera(view_row_t r0, view_row_t r1, view_row_t r2);
			pending.push_back(r0);
			pending.push_back(r1);
			pending.push_back(r2);
			cameras++;
		endfunction

		function void check_row(view_row_t got);
			view_row_t want;
			rows_seen++;
			if (got.degen) degen_seen++;
			if (pending.size() == 0) begin
				$display("%0t: row with no prediction waiting: %p", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.row !== want.row)
				$display("%0t: row_index expected %0d actual %0d", $time, want.row, got.row);
			if (got.ax !== want.ax)
				$display("%0t: axis_x expected %h actual %h", $time, want.ax, got.ax);
			if (got.ay !== want.ay)
				$display("%0t: axis_y expected %h actual %h", $time, want.ay, got.ay);
			if (got.az !== want.az)
				$display("%0t: axis_z expected %h actual %h", $time, want.az, got.az);
			if (got.ofs !== want.ofs)
				$display("%0t: offset expected %h actual %h", $time, want.ofs, got.ofs);
			if (got.degen !== want.degen)
				$display("%0t: degenerate expected %b actual %b", $time, want.degen, got.degen);
			if (got.last !== want.last)
				$display("%0t: last_row expected %b actual %b", $time, want.last, got.last);
			if (got !== want) errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] eye_x, eye_y, eye_z;
	logic signed [31:0] target_x, target_y, target_z;
	logic signed [31:0] up_x, up_y, up_z;
	logic out_valid;
	logic out_stall;
	logic [1:0] row_index;
	logic signed [31:0] axis_x, axis_y, axis_z, offset;
	logic degenerate;
	logic last_row;

	view_row_board board;
	bit            stim_done;

	lookat_view_matrix u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.row_index(row_index), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.offset(offset), .degenerate(degenerate), .last_row(last_row)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Behavioral model of the arithmetic. Values are held in 64-bit variables,
	// signed or unsigned; every product below stays inside 64 bits, as in the hardware.
	// ------------------------------------------------------------------

	function automatic longint unsigned magnitude(longint x);
		return (x < 0) ? longint'(0) - x : x;
	endfunction

	// Right shift with halves rounded away from zero.
	function automatic longint shift_round(longint x, int n);
		longint unsigned m;
		m = (magnitude(x) + (64'd1 << (n - 1))) >> n;
		return (x < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint saturate32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint clamp_one(longint x);
		if (x > 64'sd1073741824) return 64'sd1073741824;
		if (x < -64'sd1073741824) return -64'sd1073741824;
		return x;
	endfunction

	// Bit-by-bit integer square root, floor.
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Scales the vector so the largest magnitude lies in [2^30, 2^31), then
	// divides by the floor root with round-half-up. Returns 0 for a zero vector.
	function automatic bit unit_vector(input longint v[3], output longint o[3]);
		longint unsigned a[3], m, sum, n, q;
		int rs, ls;
		m = 0; sum = 0; rs = 0; ls = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = magnitude(v[i]);
			if (a[i] > m) m = a[i];
		end
		if (m == 0) return 1'b0;
		while (m >= (64'd1 << 31)) begin
			m >>= 1;
			rs++;
		end
		while (m < (64'd1 << 30)) begin
			m <<= 1;
			ls++;
		end
		for (int i = 0; i < 3; i++) begin
			a[i] = (a[i] >> rs) << ls;
			sum += a[i] * a[i];
		end
		n = floor_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((a[i] << 30) + (n >> 1)) / n;
			o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	// Works out the three view-matrix rows of one camera and hands them on.
	task automatic predict_view_rows(input logic signed [31:0] cam[9]);
		longint eye[3], dir[3], fwd[3], crs[3], side[3], upv[3], upr[3];
		longint axes[3][3], offs[3], dot;
		bit ok;
		view_row_t rows[3];
		for (int i = 0; i < 3; i++) begin
			eye[i] = cam[i];
			upr[i] = cam[6 + i];
			dir[i] = longint'(cam[3 + i]) - longint'(cam[i]);
		end
		ok = unit_vector(dir, fwd);
		if (ok) begin
			crs[0] = fwd[1] * upr[2] - fwd[2] * upr[1];
			crs[1] = fwd[2] * upr[0] - fwd[0] * upr[2];
			crs[2] = fwd[0] * upr[1] - fwd[1] * upr[0];
			ok = unit_vector(crs, side);
		end
		if (ok) begin
			upv[0] = clamp_one(shift_round(side[1] * fwd[2] - side[2] * fwd[1], 30));
			upv[1] = clamp_one(shift_round(side[2] * fwd[0] - side[0] * fwd[2], 30));
			upv[2] = clamp_one(shift_round(side[0] * fwd[1] - side[1] * fwd[0], 30));
			for (int i = 0; i < 3; i++) begin
				axes[0][i] = side[i];
				axes[1][i] = upv[i];
				axes[2][i] = -fwd[i];
			end
			for (int r = 0; r < 3; r++) begin
				dot = 0;
				for (int i = 0; i < 3; i++) dot += axes[r][i] * eye[i];
				offs[r] = saturate32(shift_round(-dot, 30));
			end
		end else begin
			for (int r = 0; r < 3; r++) begin
				for (int i = 0; i < 3; i++) axes[r][i] = 0;
				offs[r] = 0;
			end
		end
		for (int r = 0; r < 3; r++) begin
			rows[r].row   = lvm_pkg::row_t'(r);
			rows[r].ax    = axes[r][0][31:0];
			rows[r].ay    = axes[r][1][31:0];
			rows[r].az    = axes[r][2][31:0];
			rows[r].ofs   = offs[r][31:0];
			rows[r].degen = !ok;
			rows[r].last  = (r == 2);
		end
		board.note_camera(rows[0], rows[1], rows[2]);
	endtask

	// Gap length: usually none or short, now and then long.
	function automatic int idle_cycles();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Presents one camera transaction and waits until the block accepts it.
	// The model is updated at the accepting edge.
	task automatic send_camera(input logic signed [31:0] cam[9]);
		in_valid <= 1'b1;
		eye_x <= cam[0]; eye_y <= cam[1]; eye_z <= cam[2];
		target_x <= cam[3]; target_y <= cam[4]; target_z <= cam[5];
		up_x <= cam[6]; up_y <= cam[7]; up_z <= cam[8];
		do @(posedge clk); while (in_stall);
		predict_view_rows(cam);
	endtask

	// Drops valid for a random gap; valid stays up when the gap is zero so the
	// next camera follows directly.
	task automatic input_gap(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
			3: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh20000;
			default: return $urandom;
		endcase
	endfunction

	// Receiver side: random stalls, and each accepted row goes to the board.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				board.check_row('{lvm_pkg::row_t'(row_index), axis_x, axis_y, axis_z,
					offset, degenerate, last_row});
			out_stall <= ($urandom_range(99) < 30) ? 1'b1 : 1'b0;
		end
	end

	// Stimulus: directed corner cases, then random cameras.
	initial begin
		logic signed [31:0] cam[9];
		logic signed [31:0] pt;
		int t;
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		{eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z} = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain camera at the origin looking down -z with +y up.
		cam = '{0, 0, 0, 0, 0, -32'sh10000, 0, 32'sh10000, 0};
		send_camera(cam);
		// Target equal to eye: forward has no length.
		cam = '{32'sh30000, -32'sh5000, 32'sh1234, 32'sh30000, -32'sh5000, 32'sh1234,
			0, 32'sh10000, 0};
		send_camera(cam);
		// Up vector zero.
		cam = '{0, 0, 0, 32'sh10000, 32'sh20000, 0, 0, 0, 0};
		send_camera(cam);
		// Up parallel to forward.
		cam = '{32'sh10000, 0, 0, 32'sh30000, 0, 0, 32'sh50000, 0, 0};
		send_camera(cam);
		// Up antiparallel to forward.
		cam = '{0, 0, 0, 0, 32'sh20000, 0, 0, -32'sh10000, 0};
		send_camera(cam);
		// Extreme coordinates: widest difference and saturating offsets.
		cam = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 32'sh80000000};
		send_camera(cam);
		cam = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1};
		send_camera(cam);
		// Smallest nonzero forward and up.
		cam = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
		send_camera(cam);
		cam = '{-1, -1, -1, 0, 0, 0, 0, 0, -1};
		send_camera(cam);
		// Large eye with a unit step forward.
		cam = '{32'sh7fff0000, 32'sh80010000, 32'sh7fff0000,
			32'sh7fff0000, 32'sh80010000, 32'sh7ffe0000, 0, 32'sh10000, 0};
		send_camera(cam);
		// Every word all ones or all zeros, mixed.
		cam = '{-1, 0, -1, 0, -1, 0, -1, -1, 0};
		send_camera(cam);
		input_gap(idle_cycles());

		// Random cameras. Some share eye and target, some take up from the forward
		// step with each component's sign picked at random, some have a zero up, most are ordinary.
		for (int k = 0; k < 400; k++) begin
			foreach (cam[i]) cam[i] = rand_word();
			t = $urandom_range(99);
			if (t < 5) begin
				for (int i = 0; i < 3; i++) cam[3 + i] = cam[i];
			end else if (t < 10) begin
				for (int i = 0; i < 3; i++) begin
					pt = $urandom_range(0, 32'h3fff) - 32'sh2000;
					cam[3 + i] = cam[i] + pt;
					cam[6 + i] = $urandom_range(0, 1) ? pt : -pt;
				end
			end else if (t < 13) begin
				for (int i = 6; i < 9; i++) cam[i] = 0;
			end
			send_camera(cam);
			if (k % 80 > 60) input_gap(0);
			else input_gap(idle_cycles());
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Wait for the last predicted row, allow a drain margin, then report.
	initial begin
		wait (stim_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Covered %0d cameras and %0d output rows, %0d of them degenerate.",
			board.cameras, board.rows_seen, board.degen_seen);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("lookat_view_matrix regression: pass");
		else
			$display("lookat_view_matrix regression: fail");
		$finish;
	end

	// Watchdog for a hang anywhere in the run.
	initial begin
		#2000000;
		$display("Timed out with %0d rows still expected.", board.pending.size());
		$display("lookat_view_matrix regression: fail");
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
hdl/lvm_pkg.sv
hdl/lvm_norm.sv
hdl/lookat_view_matrix.sv
sim/tb_lookat_view_matrix.sv
